/* rtl/dgdm_pkg.sv */
// Package: shared types, constants and codes for the grid distance map.
`default_nettype none
package dgdm_pkg;
  localparam int GRID_ROWS_DEF   = 64;
  localparam int GRID_COLS_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 16384;
  localparam int DIST_W          = 13;
  localparam logic [DIST_W-1:0] DIST_UNKNOWN = 13'd8191;
  localparam logic [DIST_W-1:0] DIST_SAT     = 13'd8190;

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PROP   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row;
    logic [5:0] col;
  } in_word_t;

  typedef struct packed {
    logic        has_nearest;
    logic [12:0] dist_sq;
    logic [5:0]  nearest_row;
    logic [5:0]  nearest_col;
    logic        is_store;
    logic        queue_overflow;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_WR,
    ST_POP,
    ST_POP_WAIT,
    ST_CELL_RD,
    ST_CELL_EVAL,
    ST_SRC_RD,
    ST_SRC_EVAL,
    ST_NB_NEXT,
    ST_NB_RD,
    ST_NB_LIVE_RD,
    ST_NB_LIVE,
    ST_RAISE_END,
    ST_RAISE_RMW,
    ST_DONE
  } state_t;

  // queue push and pop request between sequencer and queue
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;
endpackage
`default_nettype wire

/* rtl/dgdm_ram.sv */
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module dgdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write when enabled; the registered read returns the old word during a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/dgdm_queue.sv */
// Circular work queue of cell indexes held in a RAM, with sticky overflow.
`default_nettype none
module dgdm_queue #(
  parameter int DEPTH = dgdm_pkg::QUEUE_DEPTH_DEF,
  parameter int IW    = 12
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dgdm_pkg::q_ctl_t ctl,
  input  wire logic [IW-1:0]  push_data,
  output      logic [IW-1:0]  pop_data,
  output      logic           empty,
  output      logic           overflow
);
  import dgdm_pkg::*;
  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] addr;
  logic          full;
  logic          we;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  // wrap the write slot at the queue depth
  assign tail_sum = {1'b0, head_r} + count_r;
  assign tail  = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                               : tail_sum[AW-1:0];
  assign we    = ctl.push && !full;
  assign addr  = ctl.push ? tail : head_r;
  assign overflow = ovf_r;

  // push and pop never occur together
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.push) begin
      if (full) ovf_nxt = 1'b1;
      else count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !empty) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  dgdm_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_mem (
    .clk(clk), .we(we), .addr(addr), .wdata(push_data), .rdata(pop_data)
  );
endmodule
`default_nettype wire

/* rtl/dgdm_cells.sv */
// Per-cell entry memory: occupancy, raise mark, nearest store and distance.
`default_nettype none
module dgdm_cells #(
  parameter int CELLS = 4096,
  parameter int RW    = 6,
  parameter int CW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(CELLS)-1:0] addr,
  input  wire logic [RW+CW+16-1:0]      wdata,
  output      logic [RW+CW+16-1:0]      rdata
);
  // entry: occ, raise, valid, row, col, dist
  dgdm_ram #(.WIDTH(RW+CW+16), .DEPTH(CELLS)) u_mem (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );
endmodule
`default_nettype wire

/* rtl/dynamic_grid_distance_map.sv */
// Top level: incremental brushfire distance map over a cell memory and queue.
//
//  channel | ports                         | dir | word
//  in      | in_valid in_ready in_data     | in  | opcode row col
//  out     | out_valid out_ready out_data  | out | entry and overflow flag
//  cfg     | cfg_valid cfg_ready cfg_index | in  | grid_width, grid_height
//          | cfg_data                      |     |
//
// Place, remove and query pass through the ST_CMD_RD, ST_CMD_WR and ST_DONE states
// before out_valid rises (ST_CMD_WR is skipped when the cell lies outside the grid
// in use). Propagate pops cells in turn; the single memory port orders the work:
// each cell is read, a lowering cell's store is checked, its neighbors in the grid
// are read in turn (a raise also reads each valid neighbor's store), and a raising
// cell's mark is cleared. After reset a clearing pass writes every cell entry, one
// per cycle, while in_ready stays low.
// A result waits in an output register; a new word is taken once it leaves.
`default_nettype none
module dynamic_grid_distance_map #(
  parameter int GRID_ROWS   = dgdm_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS   = dgdm_pkg::GRID_COLS_DEF,
  parameter int QUEUE_DEPTH = dgdm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire dgdm_pkg::in_word_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      dgdm_pkg::out_word_t out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [6:0]          cfg_data
);
  import dgdm_pkg::*;
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int IW    = RW + CW;
  localparam int CELLS = 1 << IW;
  localparam int SW    = 9;

  typedef struct packed {
    logic          occ;
    logic          rmk;
    logic          vld;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    logic [12:0]   d;
  } entry_t;

  localparam entry_t CLEAR_E = '{occ: 1'b0, rmk: 1'b0, vld: 1'b0, nr: '0, nc: '0,
                                 d: DIST_UNKNOWN};

  // configuration
  logic [6:0] gw_r, gh_r;
  logic [8:0] cols_u, rows_u;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 7'd64;
      gh_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) gw_r <= cfg_data;
      else gh_r <= cfg_data;
    end
  end
  always_comb begin
    cols_u = (gw_r == '0) ? 9'd1 : {2'b0, gw_r};
    if (cols_u > 9'(GRID_COLS)) cols_u = 9'(GRID_COLS);
    rows_u = (gh_r == '0) ? 9'd1 : {2'b0, gh_r};
    if (rows_u > 9'(GRID_ROWS)) rows_u = 9'(GRID_ROWS);
  end

  // cell memory and queue
  logic          m_we;
  logic [IW-1:0] m_addr;
  entry_t        m_wd, m_rd;
  q_ctl_t        qc;
  logic [IW-1:0] q_wd, q_rd;
  logic          q_empty, q_ovf;

  dgdm_cells #(.CELLS(CELLS), .RW(RW), .CW(CW)) u_cells (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );
  dgdm_queue #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_queue (
    .clk(clk), .rst_n(rst_n), .ctl(qc), .push_data(q_wd), .pop_data(q_rd),
    .empty(q_empty), .overflow(q_ovf)
  );

  // sequencer registers
  state_t        st_r, st_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  in_word_t      cmd_r, cmd_nxt;
  logic [RW-1:0] cr_r, cr_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  entry_t        src_r, src_nxt;
  entry_t        nb_r, nb_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [RW-1:0] nr_r, nr_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [12:0]   sq_r, sq_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     od_r, od_nxt;

  logic          in_grid;
  logic [IW-1:0] cmd_addr, cur_addr, nb_addr;
  logic [1:0]    k_row, k_col;
  logic [RW:0]   rr_s;
  logic [CW:0]   cc_s;
  logic          nb_ok;
  logic [RW-1:0] dr;
  logic [CW-1:0] dc;
  logic [SW+7:0] sum;

  assign in_grid = ({3'b0, cmd_r.row} < rows_u) && ({3'b0, cmd_r.col} < cols_u);

  // cell address is row and column side by side
  assign cmd_addr = {RW'(cmd_r.row), CW'(cmd_r.col)};
  assign cur_addr = {cr_r, cc_r};
  assign nb_addr  = {nr_r, nc_r};

  // neighbor k (0..8, 4 = center) as row/col offsets
  always_comb begin
    k_row = (k_r < 4'd3) ? 2'd0 : (k_r < 4'd6) ? 2'd1 : 2'd2;
    k_col = 2'(k_r - 4'd3 * {2'b0, k_row});
    rr_s = {1'b0, cr_r} + (RW+1)'(k_row) - (RW+1)'(1);
    cc_s = {1'b0, cc_r} + (CW+1)'(k_col) - (CW+1)'(1);
    nb_ok = (k_r != 4'd4) && !rr_s[RW] && !cc_s[CW] &&
            (9'(rr_s) < rows_u) && (9'(cc_s) < cols_u);
  end

  // squared distance between source store and the neighbor being selected
  always_comb begin
    dr  = (src_r.nr > RW'(rr_s)) ? src_r.nr - RW'(rr_s) : RW'(rr_s) - src_r.nr;
    dc  = (src_r.nc > CW'(cc_s)) ? src_r.nc - CW'(cc_s) : CW'(cc_s) - src_r.nc;
    sum = 17'(dr) * 17'(dr) + 17'(dc) * 17'(dc);
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; cmd_nxt = cmd_r;
    cr_nxt = cr_r; cc_nxt = cc_r; src_nxt = src_r; nb_nxt = nb_r;
    k_nxt = k_r; nr_nxt = nr_r; nc_nxt = nc_r; ov_nxt = ov_r; od_nxt = od_r;
    sq_nxt = (sum > 17'(DIST_SAT)) ? DIST_SAT : sum[12:0];
    m_we = 1'b0; m_addr = '0; m_wd = CLEAR_E;
    qc = '0; q_wd = '0;
    in_ready = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        m_we = 1'b1; m_addr = clr_r; clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(CELLS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !ov_r;
        if (in_valid && !ov_r) begin
          cmd_nxt = in_data;
          st_nxt = ST_CMD_RD;
        end
      end
      ST_CMD_RD: begin
        m_addr = cmd_addr;
        od_nxt = '0;
        if (cmd_r.opcode == OP_PROP) st_nxt = ST_POP;
        else if (!in_grid) st_nxt = ST_DONE;
        else st_nxt = ST_CMD_WR;
      end
      ST_CMD_WR: begin
        m_addr = cmd_addr;
        q_wd = m_addr;
        st_nxt = ST_DONE;
        case (cmd_r.opcode)
          OP_PLACE: begin
            m_we = 1'b1;
            m_wd = '{occ: 1'b1, rmk: m_rd.rmk, vld: 1'b1, nr: RW'(cmd_r.row),
                     nc: CW'(cmd_r.col), d: '0};
            qc.push = 1'b1;
          end
          OP_REMOVE: begin
            if (m_rd.occ) begin
              m_we = 1'b1;
              m_wd = CLEAR_E;
              m_wd.rmk = 1'b1;
              qc.push = 1'b1;
            end
          end
          default: begin
            if (m_rd.vld) begin
              od_nxt.has_nearest = 1'b1;
              od_nxt.dist_sq = m_rd.d;
              od_nxt.nearest_row = 6'(m_rd.nr);
              od_nxt.nearest_col = 6'(m_rd.nc);
            end
            od_nxt.is_store = m_rd.occ;
          end
        endcase
      end
      ST_POP: begin
        if (q_empty) st_nxt = ST_DONE;
        else st_nxt = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        // queue read data for head is now valid; pop it
        qc.pop = 1'b1;
        cr_nxt = q_rd[IW-1:CW];
        cc_nxt = q_rd[CW-1:0];
        st_nxt = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        m_addr = cur_addr;
        st_nxt = ST_CELL_EVAL;
      end
      ST_CELL_EVAL: begin
        m_addr = cur_addr;
        src_nxt = m_rd;
        k_nxt = '0;
        if (m_rd.rmk) st_nxt = ST_NB_NEXT;
        else if (m_rd.vld) st_nxt = ST_SRC_RD;
        else st_nxt = ST_POP;
      end
      ST_SRC_RD: begin
        m_addr = {src_r.nr, src_r.nc};
        st_nxt = ST_SRC_EVAL;
      end
      ST_SRC_EVAL: begin
        if (m_rd.vld && m_rd.nr == src_r.nr && m_rd.nc == src_r.nc) st_nxt = ST_NB_NEXT;
        else st_nxt = ST_POP;
      end
      ST_NB_NEXT: begin
        if (k_r == 4'd9) begin
          st_nxt = src_r.rmk ? ST_RAISE_END : ST_POP;
        end else if (!nb_ok) begin
          k_nxt = k_r + 1'b1;
        end else begin
          nr_nxt = RW'(rr_s);
          nc_nxt = CW'(cc_s);
          m_addr = {RW'(rr_s), CW'(cc_s)};
          st_nxt = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        m_addr = nb_addr;
        nb_nxt = m_rd;
        k_nxt = k_r + 1'b1;
        q_wd = m_addr;
        st_nxt = ST_NB_NEXT;
        if (!m_rd.rmk) begin
          if (src_r.rmk) begin
            if (m_rd.vld) begin
              m_addr = {m_rd.nr, m_rd.nc};
              k_nxt = k_r;
              st_nxt = ST_NB_LIVE_RD;
            end
          end else if (sq_r < m_rd.d) begin
            m_we = 1'b1;
            m_wd = m_rd;
            m_wd.d = sq_r;
            m_wd.vld = src_r.vld; m_wd.nr = src_r.nr; m_wd.nc = src_r.nc;
            qc.push = 1'b1;
          end
        end
      end
      ST_NB_LIVE_RD: begin
        m_addr = {nb_r.nr, nb_r.nc};
        st_nxt = ST_NB_LIVE;
      end
      ST_NB_LIVE: begin
        m_addr = nb_addr;
        q_wd = m_addr;
        qc.push = 1'b1;
        k_nxt = k_r + 1'b1;
        st_nxt = ST_NB_NEXT;
        if (!(m_rd.vld && m_rd.nr == nb_r.nr && m_rd.nc == nb_r.nc)) begin
          m_we = 1'b1;
          m_wd = CLEAR_E;
          m_wd.occ = nb_r.occ;
          m_wd.rmk = 1'b1;
        end
      end
      ST_RAISE_END: begin
        m_addr = cur_addr;
        st_nxt = ST_RAISE_RMW;
      end
      ST_RAISE_RMW: begin
        m_addr = cur_addr;
        m_we = 1'b1;
        m_wd = m_rd;
        m_wd.rmk = 1'b0;
        st_nxt = ST_POP;
      end
      ST_DONE: begin
        od_nxt.queue_overflow = q_ovf;
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (ov_r && out_ready) ov_nxt = (st_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; cr_r <= cr_nxt; cc_r <= cc_nxt;
    src_r <= src_nxt; nb_r <= nb_nxt; k_r <= k_nxt;
    nr_r <= nr_nxt; nc_r <= nc_nxt; sq_r <= sq_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

/* rtl/dgdm_checker.sv */
// Port-level checker for the grid distance map, bound to the top level.
`default_nettype none
module dgdm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dgdm_pkg::out_word_t out_data
);
  import dgdm_pkg::*;

  // a result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // no new word taken while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // an offered input word stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn before it was taken");

  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.queue_overflow ##1 out_valid[->1] |-> out_data.queue_overflow)
    else $error("overflow flag cleared");

  // distance present only with a nearest store
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_nearest |-> out_data.dist_sq == '0)
    else $error("distance without nearest store");
endmodule

bind dynamic_grid_distance_map dgdm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

/* bench/tb_dynamic_grid_distance_map.sv */
// Testbench for the grid distance map: a self-checking model plus random and directed words.
`timescale 1ns / 100ps

module tb_dynamic_grid_distance_map;
  import dgdm_pkg::*;

  // Predicts the distance map and checks every result word in order.
  class dist_map_board;
    localparam int ROWS  = GRID_ROWS_DEF;
    localparam int COLS  = GRID_COLS_DEF;
    localparam int CELLS = ROWS * COLS;

    bit [6:0]  width_reg, height_reg;
    bit        occ[CELLS];
    bit [12:0] cell_dist[CELLS];
    bit        near_ok[CELLS];
    bit [5:0]  near_r[CELLS], near_c[CELLS];
    bit        raise[CELLS];
    int unsigned work[$];
    bit        overflow;

    out_word_t expected_words[$];
    int errors, checked;

    function new();
      width_reg = 7'd64;
      height_reg = 7'd64;
      for (int i = 0; i < CELLS; i++) begin
        occ[i] = 0; raise[i] = 0; clear_cell(i);
      end
      overflow = 0;
    endfunction

    function void clear_cell(int i);
      cell_dist[i] = DIST_UNKNOWN;
      near_ok[i] = 0; near_r[i] = 6'd0; near_c[i] = 6'd0;
    endfunction

    function int cols_in_use();
      return (width_reg < 1) ? 1 : (width_reg > COLS) ? COLS : width_reg;
    endfunction

    function int rows_in_use();
      return (height_reg < 1) ? 1 : (height_reg > ROWS) ? ROWS : height_reg;
    endfunction

    function void write_reg(reg_idx_t idx, bit [6:0] val);
      if (idx == REG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void push(int r, int c);
      if (work.size() >= QUEUE_DEPTH_DEF) begin
        overflow = 1;
        return;
      end
      work.insert(work.size(), r * COLS + c);
    endfunction

    // a store reference is live when the named cell points at itself
    function bit live(bit ok, int r, int c);
      int j;
      if (!ok) return 0;
      j = r * COLS + c;
      return near_ok[j] && near_r[j] == r && near_c[j] == c;
    endfunction

    function int sq_dist(int r1, int c1, int r2, int c2);
      int d;
      d = (r1 - r2) * (r1 - r2) + (c1 - c2) * (c1 - c2);
      return (d > DIST_SAT) ? DIST_SAT : d;
    endfunction

    function void raise_cell(int r, int c);
      int h, w, rr, cc, n;
      h = rows_in_use(); w = cols_in_use();
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr; cc = c + dc;
          if (dr == 0 && dc == 0) continue;
          if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
          n = rr * COLS + cc;
          if (raise[n] || !near_ok[n]) continue;
          if (!live(near_ok[n], near_r[n], near_c[n])) begin
            clear_cell(n);
            raise[n] = 1;
          end
          push(rr, cc);
        end
      raise[r * COLS + c] = 0;
    endfunction

    function void lower_cell(int r, int c);
      int h, w, rr, cc, n, d, sr, sc;
      h = rows_in_use(); w = cols_in_use();
      sr = near_r[r * COLS + c]; sc = near_c[r * COLS + c];
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr; cc = c + dc;
          if (dr == 0 && dc == 0) continue;
          if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
          n = rr * COLS + cc;
          if (raise[n]) continue;
          d = sq_dist(sr, sc, rr, cc);
          if (d < cell_dist[n]) begin
            cell_dist[n] = 13'(d);
            near_ok[n] = 1; near_r[n] = 6'(sr); near_c[n] = 6'(sc);
            push(rr, cc);
          end
        end
    endfunction

    // note an accepted input word and queue its expected result
    function void note_input(in_word_t w);
      out_word_t res;
      int r, c, i;
      bit ins;
      r = w.row; c = w.col;
      ins = r < rows_in_use() && c < cols_in_use();
      i = r * COLS + c;
      res = '0;
      case (op_t'(w.opcode))
        OP_PLACE: if (ins) begin
          occ[i] = 1;
          near_ok[i] = 1; near_r[i] = 6'(r); near_c[i] = 6'(c);
          cell_dist[i] = 13'd0;
          push(r, c);
        end
        OP_REMOVE: if (ins && occ[i]) begin
          clear_cell(i);
          raise[i] = 1;
          occ[i] = 0;
          push(r, c);
        end
        OP_PROP: while (work.size() > 0) begin
          int k;
          k = work[0];
          work.delete(0);
          if (raise[k]) raise_cell(k / COLS, k % COLS);
          else if (live(near_ok[k], near_r[k], near_c[k])) lower_cell(k / COLS, k % COLS);
        end
        default: if (ins) begin
          if (near_ok[i]) begin
            res.has_nearest = 1'b1;
            res.dist_sq = cell_dist[i];
            res.nearest_row = near_r[i];
            res.nearest_col = near_c[i];
          end
          res.is_store = occ[i];
        end
      endcase
      res.queue_overflow = overflow;
      expected_words.insert(expected_words.size(), res);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare a result word with the oldest expectation
    task check_result(out_word_t got);
      out_word_t exp;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = expected_words[0];
      expected_words.delete(0);
      checked++;
      if (got.has_nearest !== exp.has_nearest)
        report($sformatf("has_nearest got %b exp %b", got.has_nearest, exp.has_nearest));
      if (got.dist_sq !== exp.dist_sq)
        report($sformatf("dist_sq got %0d exp %0d", got.dist_sq, exp.dist_sq));
      if (got.nearest_row !== exp.nearest_row)
        report($sformatf("nearest_row got %0d exp %0d", got.nearest_row, exp.nearest_row));
      if (got.nearest_col !== exp.nearest_col)
        report($sformatf("nearest_col got %0d exp %0d", got.nearest_col, exp.nearest_col));
      if (got.is_store !== exp.is_store)
        report($sformatf("is_store got %b exp %b", got.is_store, exp.is_store));
      if (got.queue_overflow !== exp.queue_overflow)
        report($sformatf("queue_overflow got %b exp %b", got.queue_overflow,
                         exp.queue_overflow));
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready;
  in_word_t in_data;
  logic out_valid, out_ready;
  out_word_t out_data;
  logic cfg_valid, cfg_ready;
  logic cfg_index;
  logic [6:0] cfg_data;

  dist_map_board board;
  bit idle_on;
  int sent, phases;

  dynamic_grid_distance_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    rst_n = 0;
    in_valid = 0; in_data = '0;
    out_ready = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = '0;
  end

  // hold each word until the block takes it
  task send_word(op_t op, int r, int c);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, row: r[5:0], col: c[5:0]};
    do @(posedge clk); while (!in_ready);
    board.note_input(in_data);
    sent++;
  endtask

  // drain all expected results, then leave the inputs idle before returning
  task wait_drained();
    in_valid <= 0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, bit [6:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // random words aimed mostly inside the grid in use
  task random_words(int count);
    int h, w, r, c, pick;
    op_t op;
    h = board.rows_in_use(); w = board.cols_in_use();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = pick < 30 ? OP_PLACE : pick < 48 ? OP_REMOVE : pick < 62 ? OP_PROP : OP_QUERY;
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 63); c = $urandom_range(0, 63);
      end else begin
        r = $urandom_range(0, h - 1); c = $urandom_range(0, w - 1);
      end
      send_word(op, r, c);
      // pause the sender once until everything has come back
      if (n == count / 2 && phases == 3) wait_drained();
    end
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (board.checked == 300) gap = 400;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end

  // watchdog: end the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 board.expected_words.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    bit [6:0] widths[10]  = '{7'd5, 7'd1, 7'd0, 7'd12, 7'd3, 7'd64, 7'd8, 7'd20, 7'd2, 7'd127};
    bit [6:0] heights[10] = '{7'd7, 7'd1, 7'd0, 7'd3, 7'd12, 7'd1, 7'd8, 7'd2, 7'd64, 7'd127};
    int area;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    idle_on = 1;

    // directed: full grid, corners, lower and raise waves, repeats
    send_word(OP_QUERY, 0, 0);
    send_word(OP_PLACE, 0, 0);
    send_word(OP_PLACE, 63, 63);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, 63, 63);
    send_word(OP_PROP, 0, 0);
    send_word(OP_QUERY, 31, 31);
    send_word(OP_QUERY, 63, 0);
    send_word(OP_QUERY, 0, 63);
    send_word(OP_REMOVE, 10, 10);
    send_word(OP_PLACE, 0, 0);
    send_word(OP_REMOVE, 63, 63);
    send_word(OP_PROP, 0, 0);
    send_word(OP_QUERY, 63, 63);
    send_word(OP_QUERY, 40, 21);
    send_word(OP_PROP, 0, 0);
    send_word(OP_REMOVE, 0, 0);
    send_word(OP_PROP, 0, 0);
    send_word(OP_QUERY, 5, 5);
    send_word(OP_QUERY, 42, 21);
    wait_drained();

    // phases over grid sizes, extremes and out-of-range values included
    for (int p = 0; p < 10; p++) begin
      phases = p;
      write_reg(REG_WIDTH, widths[p]);
      write_reg(REG_HEIGHT, heights[p]);
      idle_on = (p % 4) != 2;
      area = board.rows_in_use() * board.cols_in_use();
      if (p == 2) begin
        send_word(OP_QUERY, 0, 1);
        send_word(OP_PLACE, 1, 0);
        send_word(OP_QUERY, 1, 0);
      end
      random_words(area > 400 ? 30 : 240);
      wait_drained();
    end

    $display("covered %0d words over %0d grid settings, %0d results checked",
             sent, phases + 2, board.checked);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/dgdm_pkg.sv
rtl/dgdm_ram.sv
rtl/dgdm_queue.sv
rtl/dgdm_cells.sv
rtl/dynamic_grid_distance_map.sv
rtl/dgdm_checker.sv
bench/tb_dynamic_grid_distance_map.sv
